@@ hdl/sblc_pkg.sv @@
// ----------------------------------------------------------------------------
// sblc_pkg: shared types and constants
// Widths, table depth, command codes and sequencer states for the LRU cache.
// ----------------------------------------------------------------------------
`default_nettype none
package sblc_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 64;
   localparam int HDL_W   = 32;
   localparam int SIZE_W  = 40;
   localparam int TOT_W   = 48;
   localparam int STAMP_W = 48;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_TRIM   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,     // key search, one slot per cycle
      ST_HIT,      // wait for handle read
      ST_OLD,      // oldest search, one slot per cycle
      ST_OLD_DROP, // drop the oldest found
      ST_FREE,     // lowest free slot search
      ST_INSERT,
      ST_SUM,      // recount total, one slot per cycle
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

@@ hdl/sblc_ram.sv @@
// ----------------------------------------------------------------------------
// sblc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module sblc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hdl/size_bounded_lru_cache.sv @@
// ----------------------------------------------------------------------------
// size_bounded_lru_cache: byte-bounded LRU cache of value handles
// Sequencer walks a slot table held in RAMs, one slot per cycle, sharing
// one scan counter and read address across lookup, oldest search and recount.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  req      | req_valid/ready, cmd,key,handle,size    | in
//  rsp      | rsp_valid/ready, hit,value,sum,count    | out
//  csr      | csr_wr_en, csr_wr_data (capacity)       | in
//
// Steps: a table walk issues one slot read per cycle, takes the last registered
// read, then closes. A lookup hit is a find walk, a handle read and the response;
// a miss is a find walk, free-slot pick, insert and a recount walk (then response),
// plus an oldest walk and a drop per evicted entry or for a full-table replacement.
// Reset clears control, valid bits, counter and total; no clearing pass.
// The block takes no item until the result register is empty.
// ----------------------------------------------------------------------------
`default_nettype none
module size_bounded_lru_cache
   import sblc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [HDL_W-1:0]  req_value_handle,
   input  wire logic [SIZE_W-1:0] req_entry_size,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_hit,
   output logic [HDL_W-1:0]       rsp_value_out,
   output logic [TOT_W-1:0]       rsp_size_sum,
   output logic [CNT_W-1:0]       rsp_entry_count,
   input  wire logic              csr_wr_en,
   input  wire logic [TOT_W-1:0]  csr_wr_data
);
   localparam logic [TOT_W-1:0] TOT_MAX = '1;

   state_type state_ff, state_in;
   logic [TOT_W-1:0]  cap_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [STAMP_W-1:0] ctr_ff, ctr_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   cmd_type           cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [HDL_W-1:0]  hdl_ff, hdl_in;
   logic [SIZE_W-1:0] size_ff, size_in;

   // walk: scan index (read addr), pipelined index of the returned data
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              dv_ff, dv_in;
   logic [IDX_W-1:0]  didx_ff, didx_in;

   // search results
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [STAMP_W-1:0] bstamp_ff, bstamp_in;
   logic [SIZE_W-1:0] bsize_ff, bsize_in;
   logic [TOT_W-1:0]  excess_ff, excess_in;
   logic [TOT_W:0]    freed_ff, freed_in;
   logic              ins_ff, ins_in;  // oldest walk is for insertion room
   logic [TOT_W:0]    acc_ff, acc_in;

   logic              rv_ff, rv_in;
   logic              rhit_ff, rhit_in;
   logic [HDL_W-1:0]  rval_ff, rval_in;

   // RAM ports
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [KEY_W-1:0]  rd_key;
   logic [HDL_W-1:0]  rd_hdl;
   logic [SIZE_W-1:0] rd_size;
   logic [STAMP_W-1:0] rd_stamp, wr_stamp;
   logic              stamp_wr;

   sblc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key (
      .clock, .wr_en(wr_en), .wr_addr, .wr_data(key_ff), .rd_addr, .rd_data(rd_key));
   sblc_ram #(.WIDTH(HDL_W), .DEPTH(ENTRIES)) u_hdl (
      .clock, .wr_en(wr_en), .wr_addr, .wr_data(hdl_ff), .rd_addr, .rd_data(rd_hdl));
   sblc_ram #(.WIDTH(SIZE_W), .DEPTH(ENTRIES)) u_size (
      .clock, .wr_en(wr_en), .wr_addr, .wr_data(size_ff), .rd_addr, .rd_data(rd_size));
   sblc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp (
      .clock, .wr_en(stamp_wr), .wr_addr, .wr_data(wr_stamp), .rd_addr,
      .rd_data(rd_stamp));

   assign rd_addr   = scan_ff[IDX_W-1:0];
   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_hit   = rhit_ff;
   assign rsp_value_out   = rval_ff;
   assign rsp_size_sum    = total_ff;
   assign rsp_entry_count = count_ff;

   logic walk_done;
   assign walk_done = (scan_ff == CNT_W'(ENTRIES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= '0;
         valid_ff <= '0;
         ctr_ff   <= '0;
         total_ff <= '0;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= csr_wr_en ? csr_wr_data : cap_ff;
         valid_ff <= valid_in;
         ctr_ff   <= ctr_in;
         total_ff <= total_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      cmd_ff <= cmd_in;  key_ff <= key_in;  hdl_ff <= hdl_in;  size_ff <= size_in;
      scan_ff <= scan_in; dv_ff <= dv_in; didx_ff <= didx_in;
      found_ff <= found_in; best_ff <= best_in; bstamp_ff <= bstamp_in;
      bsize_ff <= bsize_in; excess_ff <= excess_in; freed_ff <= freed_in;
      ins_ff <= ins_in; acc_ff <= acc_in;
      rhit_ff <= rhit_in; rval_ff <= rval_in;
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      ctr_in   = ctr_ff;
      total_in = total_ff;
      count_in = count_ff;
      cmd_in = cmd_ff; key_in = key_ff; hdl_in = hdl_ff; size_in = size_ff;
      scan_in = scan_ff; dv_in = 1'b0; didx_in = scan_ff[IDX_W-1:0];
      found_in = found_ff; best_in = best_ff; bstamp_in = bstamp_ff;
      bsize_in = bsize_ff; excess_in = excess_ff; freed_in = freed_ff;
      ins_in = ins_ff; acc_in = acc_ff;
      rv_in = rv_ff && !rsp_ready;
      rhit_in = rhit_ff; rval_in = rval_ff;
      wr_en = 1'b0; stamp_wr = 1'b0;
      wr_addr = best_ff; wr_stamp = ctr_ff + STAMP_W'(1);

      // walk advance: issue one read per cycle
      if (state_ff == ST_FIND || state_ff == ST_OLD || state_ff == ST_SUM) begin
         if (!walk_done) begin
            scan_in = scan_ff + CNT_W'(1);
            dv_in   = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            scan_in = '0; found_in = 1'b0;
            if (req_valid && req_ready) begin
               // result fields held until the next item is taken
               rhit_in = 1'b0; rval_in = '0;
               cmd_in = cmd_type'(req_cmd); key_in = req_key;
               hdl_in = req_value_handle; size_in = req_entry_size;
               case (cmd_type'(req_cmd))
                  CMD_LOOKUP: state_in = (cap_ff != '0) ? ST_FIND : ST_RESP;
                  CMD_REMOVE: state_in = ST_FIND;
                  CMD_TRIM: begin
                     excess_in = total_ff - cap_ff; freed_in = '0; ins_in = 1'b0;
                     if (total_ff > cap_ff) begin
                        state_in = (total_ff == total_ff - cap_ff) ? ST_SUM : ST_OLD;
                        if (cap_ff == '0) valid_in = '0;
                     end else state_in = ST_RESP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_FIND: begin
            if (dv_ff && !found_ff && valid_ff[didx_ff] && rd_key == key_ff) begin
               found_in = 1'b1; best_in = didx_ff;
            end
            if (walk_done && !dv_ff) begin
               scan_in = '0;
               if (found_ff) begin
                  if (cmd_ff == CMD_LOOKUP) begin
                     scan_in = CNT_W'(best_ff);
                     stamp_wr = 1'b1; wr_addr = best_ff; ctr_in = ctr_ff + STAMP_W'(1);
                     state_in = ST_HIT;
                  end else begin
                     valid_in[best_ff] = 1'b0;
                     state_in = ST_SUM;
                  end
               end else if (cmd_ff == CMD_LOOKUP) begin
                  freed_in = '0; ins_in = 1'b0; excess_in = total_ff - cap_ff;
                  // total equal to capacity leaves nothing to free
                  if (total_ff > cap_ff) begin
                     if (cap_ff == '0 || total_ff - cap_ff == total_ff) begin
                        valid_in = '0; state_in = ST_FREE;
                     end else state_in = ST_OLD;
                  end else state_in = ST_FREE;
               end else state_in = ST_RESP;
            end
         end
         ST_HIT: begin
            // registered read of the hit slot's handle
            dv_in = 1'b1;
            if (dv_ff) begin
               rhit_in = 1'b1; rval_in = rd_hdl; state_in = ST_RESP;
            end
         end
         ST_OLD: begin
            if (dv_ff && valid_ff[didx_ff] && (!found_ff || rd_stamp < bstamp_ff)) begin
               found_in = 1'b1; best_in = didx_ff;
               bstamp_in = rd_stamp; bsize_in = rd_size;
            end
            if (walk_done && !dv_ff) begin
               scan_in = '0;
               state_in = found_ff ? ST_OLD_DROP :
                          ((cmd_ff == CMD_LOOKUP) ? ST_FREE : ST_SUM);
            end
         end
         ST_OLD_DROP: begin
            valid_in[best_ff] = 1'b0;
            found_in = 1'b0;
            freed_in = freed_ff + (TOT_W+1)'(bsize_ff);
            if (ins_ff) state_in = ST_INSERT;
            else if (freed_ff + (TOT_W+1)'(bsize_ff) < (TOT_W+1)'(excess_ff))
               state_in = ST_OLD;
            else state_in = (cmd_ff == CMD_LOOKUP) ? ST_FREE : ST_SUM;
         end
         ST_FREE: begin
            // priority pick of lowest free valid bit (per-slot flags)
            found_in = 1'b0;
            for (int i = ENTRIES - 1; i >= 0; i--) begin
               if (!valid_ff[i]) begin
                  found_in = 1'b1; best_in = IDX_W'(i);
               end
            end
            if (&valid_ff) begin
               ins_in = 1'b1; found_in = 1'b0; scan_in = '0; state_in = ST_OLD;
            end else state_in = ST_INSERT;
         end
         ST_INSERT: begin
            wr_en = 1'b1; stamp_wr = 1'b1; wr_addr = best_ff;
            ctr_in = ctr_ff + STAMP_W'(1);
            valid_in[best_ff] = 1'b1;
            scan_in = '0; state_in = ST_SUM;
         end
         ST_SUM: begin
            if (scan_ff == '0 && !dv_ff) begin
               acc_in = '0; count_in = '0;
            end
            if (dv_ff && valid_ff[didx_ff]) begin
               acc_in = acc_ff + (TOT_W+1)'(rd_size);
               if (acc_in > (TOT_W+1)'(TOT_MAX)) acc_in = (TOT_W+1)'(TOT_MAX);
               count_in = count_ff + CNT_W'(1);
            end
            if (walk_done && !dv_ff) begin
               total_in = acc_ff[TOT_W-1:0];
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rv_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTH
   // no new item while a result is pending
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_ready) else $error("item accepted with result pending");
   // count never exceeds table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES)) else $error("entry count out of range");
   // a hit result always came from a lookup
   a_hit_lookup: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rhit_ff) |-> cmd_ff == CMD_LOOKUP) else $error("hit on non-lookup");
`endif
endmodule
`default_nettype wire

@@ tb/sv/tb_size_bounded_lru_cache.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_size_bounded_lru_cache: self-checking bench for the byte-bounded LRU cache
// Drives lookup, remove, trim and no-op items against a behavioral copy of the cache
// table and compares each response field by field. Capacity is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_size_bounded_lru_cache;
   import sblc_pkg::*;

   localparam int  NSLOT     = ENTRIES;
   localparam int  WALK      = NSLOT + 1;
   localparam int  IDLE_WAIT = 16 * WALK;
   localparam int  WD_LIMIT  = 400 * WALK;   // longest miss + long stall, many times over
   localparam logic [TOT_W-1:0] SAT48 = {TOT_W{1'b1}};

   typedef struct packed {
      cmd_type             cmd;
      logic [KEY_W-1:0]    key;
      logic [HDL_W-1:0]    handle;
      logic [SIZE_W-1:0]   size;
   } req_item_type;

   typedef struct packed {
      logic                hit;
      logic [HDL_W-1:0]    value;
      logic [TOT_W-1:0]    total;
      logic [CNT_W-1:0]    count;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = '0;
   logic [KEY_W-1:0] req_key = '0;
   logic [HDL_W-1:0] req_value_handle = '0;
   logic [SIZE_W-1:0] req_entry_size = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic [HDL_W-1:0] rsp_value_out;
   logic [TOT_W-1:0] rsp_size_sum;
   logic [CNT_W-1:0] rsp_entry_count;
   logic csr_wr_en = 1'b0;
   logic [TOT_W-1:0] csr_wr_data = '0;

   size_bounded_lru_cache dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_cmd, .req_key, .req_value_handle, .req_entry_size,
      .rsp_valid, .rsp_ready, .rsp_hit, .rsp_value_out, .rsp_size_sum, .rsp_entry_count,
      .csr_wr_en, .csr_wr_data
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Behavioral cache table
   // ---------------------------------------------------------------------
   logic [TOT_W-1:0]   cap_bytes;
   logic               tbl_valid [NSLOT];
   logic [KEY_W-1:0]   tbl_key   [NSLOT];
   logic [HDL_W-1:0]   tbl_handle[NSLOT];
   logic [SIZE_W-1:0]  tbl_size  [NSLOT];
   logic [STAMP_W-1:0] tbl_stamp [NSLOT];
   logic [STAMP_W-1:0] use_clock;
   logic [TOT_W-1:0]   bytes_held;

   function automatic logic [STAMP_W-1:0] fresh_stamp();
      use_clock = use_clock + 1'b1;
      return use_clock;
   endfunction

   function automatic void sum_bytes();
      logic [TOT_W+1:0] acc;
      acc = '0;
      for (int i = 0; i < NSLOT; i++) begin
         if (tbl_valid[i]) begin
            acc = acc + tbl_size[i];
            if (acc > SAT48) acc = SAT48;
         end
      end
      bytes_held = acc[TOT_W-1:0];
   endfunction

   function automatic int slot_of(logic [KEY_W-1:0] k);
      for (int i = 0; i < NSLOT; i++)
         if (tbl_valid[i] && tbl_key[i] == k) return i;
      return -1;
   endfunction

   // lowest index wins on equal stamps
   function automatic int lru_slot();
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++)
         if (tbl_valid[i] && (best < 0 || tbl_stamp[i] < tbl_stamp[best])) best = i;
      return best;
   endfunction

   function automatic void shed(logic [TOT_W-1:0] excess);
      logic [TOT_W+1:0] freed;
      int o;
      freed = '0;
      if (excess == bytes_held) begin
         for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
      end else begin
         while (freed < excess) begin
            o = lru_slot();
            if (o < 0) break;
            freed = freed + tbl_size[o];
            tbl_valid[o] = 1'b0;
         end
      end
      sum_bytes();
   endfunction

   function automatic rsp_item_type cache_step(req_item_type it);
      rsp_item_type r;
      int s;
      int n;
      r = '0;
      if (it.cmd == CMD_LOOKUP && cap_bytes != 0) begin
         s = slot_of(it.key);
         if (s >= 0) begin
            tbl_stamp[s] = fresh_stamp();
            r.hit = 1'b1;
            r.value = tbl_handle[s];
         end else begin
            if (bytes_held >= cap_bytes) shed(bytes_held - cap_bytes);
            s = -1;
            for (int i = 0; i < NSLOT; i++)
               if (!tbl_valid[i]) begin
                  s = i;
                  break;
               end
            if (s < 0) begin
               s = lru_slot();   // table full: oldest makes room
               if (s < 0) s = 0;
            end
            tbl_valid[s]  = 1'b1;
            tbl_key[s]    = it.key;
            tbl_handle[s] = it.handle;
            tbl_size[s]   = it.size;
            tbl_stamp[s]  = fresh_stamp();
            sum_bytes();
         end
      end else if (it.cmd == CMD_REMOVE) begin
         s = slot_of(it.key);
         if (s >= 0) begin
            tbl_valid[s] = 1'b0;
            sum_bytes();
         end
      end else if (it.cmd == CMD_TRIM) begin
         if (bytes_held > cap_bytes) shed(bytes_held - cap_bytes);
      end
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (tbl_valid[i]) n++;
      r.total = bytes_held;
      r.count = n[CNT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Queues and counters
   // ---------------------------------------------------------------------
   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int  errors = 0;
   int  rsp_seen = 0, hits_seen = 0;
   int  idle_cycles = 0;
   bit  quiet_mode = 1'b0;      // no idling in the closing part
   bit  hold_rsp = 1'b0;        // long receiver hold-off request
   int  req_gap = 0, rsp_gap = 0, hold_left = 0;

   // Handshake seen at the rising edge, used by the driver at the falling edge.
   logic req_ready_q = 1'b0;

   // Driver: present items at falling edge, random gaps between them.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_q) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_item_type it;
               it = pending_reqs.pop_front();
               req_cmd <= it.cmd;
               req_key <= it.key;
               req_value_handle <= it.handle;
               req_entry_size <= it.size;
               req_valid <= 1'b1;
               if (!quiet_mode && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_ready_q <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         req_item_type it;
         it.cmd = cmd_type'(req_cmd);
         it.key = req_key;
         it.handle = req_value_handle;
         it.size = req_entry_size;
         expected_rsps.push_back(cache_step(it));
      end
   end

   // Receiver: ready at falling edge, random stalls and one long hold-off.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_rsp && hold_left == 0) hold_left <= 600;
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
            if (hold_left == 1) hold_rsp <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 7) == 0) rsp_gap <= $urandom_range(1, 11);
         end
      end
   end

   // Monitor: compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_item_type e;
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            $error("response with no item outstanding");
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (e.hit) hits_seen++;
            if (rsp_hit !== e.hit) begin
               $error("hit: expected %0h got %0h", e.hit, rsp_hit);
               errors++;
            end
            if (rsp_value_out !== e.value) begin
               $error("value_out: expected %0h got %0h", e.value, rsp_value_out);
               errors++;
            end
            if (rsp_size_sum !== e.total) begin
               $error("size_sum: expected %0h got %0h", e.total, rsp_size_sum);
               errors++;
            end
            if (rsp_entry_count !== e.count) begin
               $error("entry_count: expected %0d got %0d", e.count, rsp_entry_count);
               errors++;
            end
         end
      end
   end

   // Watchdog: cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WD_LIMIT) begin
         $display("watchdog expired, %0d items still expected", expected_rsps.size());
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   logic [KEY_W-1:0] key_pool[16];

   function automatic req_item_type mk(cmd_type c, logic [KEY_W-1:0] k,
                                       logic [HDL_W-1:0] h, logic [SIZE_W-1:0] s);
      req_item_type it;
      it.cmd = c; it.key = k; it.handle = h; it.size = s;
      return it;
   endfunction

   function automatic logic [SIZE_W-1:0] rand_size(int mode);
      case (mode)
         0: return SIZE_W'($urandom_range(0, 64));
         1: return SIZE_W'({$urandom(), $urandom()});
         default: return SIZE_W'($urandom_range(1, 300));
      endcase
   endfunction

   function automatic req_item_type rand_item(int size_mode);
      req_item_type it;
      int r;
      r = $urandom_range(0, 99);
      it.key = (r < 85) ? key_pool[$urandom_range(0, 15)] : {$urandom(), $urandom()};
      it.handle = $urandom();
      it.size = rand_size(size_mode);
      r = $urandom_range(0, 99);
      if (r < 70) it.cmd = CMD_LOOKUP;
      else if (r < 85) it.cmd = CMD_REMOVE;
      else if (r < 96) it.cmd = CMD_TRIM;
      else it.cmd = CMD_NONE;
      return it;
   endfunction

   // Wait for the block to drain, then write capacity while idle.
   task automatic write_budget(logic [TOT_W-1:0] c);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= c;
      cap_bytes = c;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(logic [TOT_W-1:0] c, int n, int size_mode);
      write_budget(c);
      for (int i = 0; i < n; i++) pending_reqs.push_back(rand_item(size_mode));
   endtask

   initial begin
      cap_bytes = '0;
      use_clock = '0;
      bytes_held = '0;
      for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
      for (int i = 0; i < 16; i++) key_pool[i] = {$urandom(), $urandom()};
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: disabled cache, then field extremes and every command.
      pending_reqs.push_back(mk(CMD_LOOKUP, '0, '1, '1));
      pending_reqs.push_back(mk(CMD_TRIM, '1, '0, '0));
      write_budget(1000);
      pending_reqs.push_back(mk(CMD_LOOKUP, '0, '1, 0));
      pending_reqs.push_back(mk(CMD_LOOKUP, '1, 32'h5555_aaaa, 400));
      pending_reqs.push_back(mk(CMD_LOOKUP, '0, '0, 0));          // hit
      pending_reqs.push_back(mk(CMD_LOOKUP, 64'h3, 32'h3, 700));  // over budget
      pending_reqs.push_back(mk(CMD_LOOKUP, 64'h4, 32'h4, 100));  // partial eviction
      pending_reqs.push_back(mk(CMD_REMOVE, 64'h4, '1, '1));
      pending_reqs.push_back(mk(CMD_REMOVE, 64'h99, '0, '0));     // absent
      pending_reqs.push_back(mk(CMD_NONE, '1, '1, '1));
      pending_reqs.push_back(mk(CMD_LOOKUP, 64'h5, 32'h5, '1));   // huge entry
      pending_reqs.push_back(mk(CMD_LOOKUP, 64'h6, 32'h6, 10));   // evicts everything
      write_budget(5);
      pending_reqs.push_back(mk(CMD_TRIM, '0, '0, '0));
      write_budget('1);
      // fill beyond table depth: table-full replacement, equal-size entries
      for (int i = 0; i < NSLOT + 4; i++)
         pending_reqs.push_back(mk(CMD_LOOKUP, 64'h100 + i, i, '1));
      write_budget(1);
      pending_reqs.push_back(mk(CMD_TRIM, '0, '0, '0));

      // Random phases at several capacities.
      run_phase(1500, 250, 2);
      hold_rsp = 1'b1;   // receiver holds off while the sender keeps offering
      run_phase(200, 200, 0);
      run_phase('1, 200, 1);
      run_phase(48'h10_0000_0000, 200, 1);
      run_phase(1, 150, 0);
      run_phase(0, 50, 2);
      quiet_mode = 1'b1;
      run_phase(3000, 300, 2);

      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
      $display("covered %0d responses, %0d lookup hits, capacities 0 to max",
               rsp_seen, hits_seen);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
hdl/sblc_pkg.sv
hdl/sblc_ram.sv
hdl/size_bounded_lru_cache.sv
tb/sv/tb_size_bounded_lru_cache.sv
